// ----- hw/rtl/esc_pkg.sv -----
// Shared types, codes and helpers for the sensor compensation block.
`timescale 1ns / 1ps
package esc_pkg;

    localparam int ACT_W   = 2;
    localparam int RAW_W   = 20;
    localparam int VAL_W   = 33;
    localparam int IDX_W   = 3;
    localparam int CDATA_W = 64;

    localparam logic [ACT_W-1:0] ACT_TEMP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PRESS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HUM   = 2'd2;

    localparam logic [IDX_W-1:0] REG_TEMP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_A = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_B = 3'd2;
    localparam logic [IDX_W-1:0] REG_P9      = 3'd3;
    localparam logic [IDX_W-1:0] REG_HUM_A   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HUM_B   = 3'd5;

    localparam logic [31:0] C_64000   = 32'd64000;
    localparam logic [31:0] C_1M      = 32'd1048576;
    localparam logic [31:0] C_3125    = 32'd3125;
    localparam logic [31:0] C_76800   = 32'd76800;
    localparam logic [31:0] C_16384   = 32'd16384;
    localparam logic [31:0] C_32768   = 32'd32768;
    localparam logic [31:0] C_2097152 = 32'd2097152;
    localparam logic [31:0] C_8192    = 32'd8192;
    localparam logic [31:0] C_HUM_MAX = 32'd419430400;
    localparam logic [31:0] C_128     = 32'd128;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TEMP  = 6'b000010,
        S_PRESS = 6'b000100,
        S_DIV   = 6'b001000,
        S_HUM   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

// ----- hw/rtl/esc_if.sv -----
// Handshake channel interfaces for sample input, result output and configuration.
`timescale 1ns / 1ps
interface esc_in_if import esc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [RAW_W-1:0] raw_sample;
    modport source (output valid, action, raw_sample, input ready);
    modport sink   (input valid, action, raw_sample, output ready);
endinterface

interface esc_out_if import esc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] comp_value;
    logic                    invalid;
    modport source (output valid, comp_value, invalid, input ready);
    modport sink   (input valid, comp_value, invalid, output ready);
endinterface

interface esc_cfg_if import esc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/env_sensor_compensation.sv -----
// Sensor compensation: sequencer around one shared 32x32 multiplier and a serial divider.
//
// Channels: i_in takes one item (action, raw_sample); o_out gives one result
// item (comp_value, invalid) per input item; i_cfg writes calibration
// registers 0..5 by index, indexes 6 and 7 are dropped. i_cfg is always ready.
// An item is taken only while the sequencer is idle; it then runs one step
// per cycle through the shared multiplier:
//   temperature  4 steps, including the result load
//   pressure     13 steps plus a 32-bit restoring divide
//   humidity     11 steps, including the result load
//   action 3     result 0, straight to the finish state
// The divide, one quotient bit per cycle, sets the worst case.
// Results land in an output register; the next item is taken while it waits.
// If the receiver stalls with a result still held, a finished item waits in
// the sequencer until the output register frees up.
// Reset clears all calibration registers, the fine temperature and the
// output valid flag.
`timescale 1ns / 1ps
module env_sensor_compensation import esc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esc_in_if.sink        i_in,
    esc_out_if.source     o_out,
    esc_cfg_if.sink       i_cfg
);

    t_state r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_flag, n_flag;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic [31:0] r_ft, n_ft;
    logic [31:0] r_ra, n_ra, r_rb, n_rb, r_rc, n_rc, r_rs, n_rs, r_rx, n_rx;
    logic [31:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_res, n_res;
    logic        r_inv, n_inv;
    logic        r_ovalid, n_ovalid;
    logic [VAL_W-1:0] r_oval, n_oval;
    logic        r_oinv, n_oinv;

    logic [47:0] r_tc;
    logic [63:0] r_pa, r_pb;
    logic [15:0] r_p9;
    logic [31:0] r_ha, r_hb;

    logic [31:0] m_a, m_b, m_p;
    logic [31:0] w_raw, w_t1, w_t2, w_t3;
    logic [31:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;
    logic [31:0] w_q, w_ft;
    logic [33:0] w_trial;
    logic        w_accept;

    assign w_raw = {12'd0, r_raw};
    assign w_t1  = {16'd0, r_tc[15:0]};
    assign w_t2  = sx16(r_tc[31:16]);
    assign w_t3  = sx16(r_tc[47:32]);
    assign w_p1  = {16'd0, r_pa[15:0]};
    assign w_p2  = sx16(r_pa[31:16]);
    assign w_p3  = sx16(r_pa[47:32]);
    assign w_p4  = sx16(r_pa[63:48]);
    assign w_p5  = sx16(r_pb[15:0]);
    assign w_p6  = sx16(r_pb[31:16]);
    assign w_p7  = sx16(r_pb[47:32]);
    assign w_p8  = sx16(r_pb[63:48]);
    assign w_p9  = sx16(r_p9);
    assign w_h1  = {24'd0, r_ha[7:0]};
    assign w_h2  = sx16(r_ha[23:8]);
    assign w_h3  = {24'd0, r_ha[31:24]};
    assign w_h4  = sx12(r_hb[11:0]);
    assign w_h5  = sx12(r_hb[23:12]);
    assign w_h6  = sx8(r_hb[31:24]);

    // undo the pre-shift when the dividend was too large to double
    assign w_q     = r_flag ? {r_rs[30:0], 1'b0} : r_rs;
    assign w_ft    = r_ra + r_rb;
    assign w_trial = {1'b0, r_rem, r_rs[31]} - {2'b00, r_ra};

    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid      = r_ovalid;
    assign o_out.comp_value = r_oval;
    assign o_out.invalid    = r_oinv;

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_TEMP: begin
                case (r_step)
                    4'd0: begin m_a = asr(w_raw, 3) - {w_t1[30:0], 1'b0}; m_b = w_t2; end
                    4'd1: begin m_a = asr(w_raw, 4) - w_t1; m_b = asr(w_raw, 4) - w_t1; end
                    4'd2: begin m_a = r_rb; m_b = w_t3; end
                    4'd3: begin m_a = w_ft; m_b = 32'd5; end
                    default: ;
                endcase
            end
            S_PRESS: begin
                case (r_step)
                    4'd1:  begin m_a = asr(r_ra, 2); m_b = asr(r_ra, 2); end
                    4'd2:  begin m_a = asr(r_rs, 11); m_b = w_p6; end
                    4'd3:  begin m_a = r_ra; m_b = w_p5; end
                    4'd4:  begin m_a = w_p3; m_b = asr(r_rs, 13); end
                    4'd5:  begin m_a = w_p2; m_b = r_ra; end
                    4'd6:  begin m_a = C_32768 + r_rc; m_b = w_p1; end
                    4'd7:  begin m_a = (C_1M - w_raw) - asr(r_rb, 12); m_b = C_3125; end
                    4'd9:  begin m_a = w_q >> 3; m_b = w_q >> 3; end
                    4'd10: begin m_a = w_p9; m_b = r_rx; end
                    4'd11: begin m_a = r_rs >> 2; m_b = w_p8; end
                    default: ;
                endcase
            end
            S_HUM: begin
                case (r_step)
                    4'd1: begin m_a = w_h5; m_b = r_rx; end
                    4'd3: begin m_a = r_rx; m_b = w_h6; end
                    4'd4: begin m_a = r_rx; m_b = w_h3; end
                    4'd5: begin m_a = r_rb; m_b = r_rc; end
                    4'd6: begin m_a = r_rb + C_2097152; m_b = w_h2; end
                    4'd7: begin m_a = r_ra; m_b = r_rb; end
                    4'd8: begin m_a = asr(r_rx, 15); m_b = asr(r_rx, 15); end
                    4'd9: begin m_a = r_rs; m_b = w_h1; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign m_p = m_a * m_b;

    always_comb begin
        logic [31:0] v_x;
        n_state  = r_state;
        n_step   = r_step + 4'd1;
        n_cnt    = r_cnt;
        n_flag   = r_flag;
        n_raw    = r_raw;
        n_ft     = r_ft;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_rc     = r_rc;
        n_rs     = r_rs;
        n_rx     = r_rx;
        n_rem    = r_rem;
        n_res    = r_res;
        n_inv    = r_inv;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oval   = r_oval;
        n_oinv   = r_oinv;
        v_x      = r_rx - r_rs;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    n_raw = i_in.raw_sample;
                    n_inv = 1'b0;
                    case (i_in.action)
                        ACT_TEMP:  n_state = S_TEMP;
                        ACT_PRESS: n_state = S_PRESS;
                        ACT_HUM:   n_state = S_HUM;
                        default: begin
                            n_res   = '0;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_TEMP: begin
                case (r_step)
                    4'd0: n_ra = asr(m_p, 11);
                    4'd1: n_rb = asr(m_p, 12);
                    4'd2: n_rb = asr(m_p, 14);
                    default: begin
                        n_ft    = w_ft;
                        n_res   = {{(VAL_W-32){m_p[31]}}, asr(m_p + C_128, 8)};
                        n_res   = {{(VAL_W-32){n_res[31]}}, n_res[31:0]};
                        n_state = S_FIN;
                    end
                endcase
            end
            S_PRESS: begin
                case (r_step)
                    4'd0: n_ra = asr(r_ft, 1) - C_64000;
                    4'd1: n_rs = m_p;
                    4'd2: n_rb = m_p;
                    4'd3: n_rb = r_rb + {m_p[30:0], 1'b0};
                    4'd4: begin
                        n_rb = asr(r_rb, 2) + {w_p4[15:0], 16'd0};
                        n_rc = asr(m_p, 3);
                    end
                    4'd5: n_rc = asr(r_rc + asr(m_p, 1), 18);
                    4'd6: n_ra = asr(m_p, 15);
                    4'd7: begin
                        if (r_ra == '0) begin
                            n_res   = '0;
                            n_inv   = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            n_rs = m_p;
                        end
                    end
                    4'd8: begin
                        // double before dividing unless the top bit is set
                        n_flag  = r_rs[31];
                        n_rs    = r_rs[31] ? r_rs : {r_rs[30:0], 1'b0};
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                    4'd9: begin
                        n_rs = w_q;
                        n_rx = m_p >> 13;
                    end
                    4'd10: n_rc = asr(m_p, 12);
                    4'd11: n_rb = asr(m_p, 13);
                    default: begin
                        n_res   = {1'b0, r_rs + asr(r_rc + r_rb + w_p7, 4)};
                        n_state = S_FIN;
                    end
                endcase
            end
            S_DIV: begin
                // one restoring quotient bit per cycle, shifted into r_rs
                n_step = r_step;
                if (!w_trial[33]) begin
                    n_rem = w_trial[31:0];
                    n_rs  = {r_rs[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_rs[31]};
                    n_rs  = {r_rs[30:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_step  = 4'd9;
                    n_state = S_PRESS;
                end
            end
            S_HUM: begin
                case (r_step)
                    4'd0: n_rx = r_ft - C_76800;
                    4'd1: n_ra = m_p;
                    4'd2: n_ra = asr({r_raw[17:0], 14'd0} - {w_h4[11:0], 20'd0}
                                     - r_ra + C_16384, 15);
                    4'd3: n_rb = asr(m_p, 10);
                    4'd4: n_rc = asr(m_p, 11) + C_32768;
                    4'd5: n_rb = asr(m_p, 10);
                    4'd6: n_rb = asr(m_p + C_8192, 14);
                    4'd7: n_rx = m_p;
                    4'd8: n_rs = asr(m_p, 7);
                    4'd9: n_rs = asr(m_p, 4);
                    default: begin
                        if (v_x[31]) begin
                            v_x = '0;
                        end else if (v_x > C_HUM_MAX) begin
                            v_x = C_HUM_MAX;
                        end
                        n_res   = {13'd0, v_x[31:12]};
                        n_state = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_res;
                    n_oinv   = r_inv;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_ft     <= '0;
            r_tc     <= '0;
            r_pa     <= '0;
            r_pb     <= '0;
            r_p9     <= '0;
            r_ha     <= '0;
            r_hb     <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_ft     <= n_ft;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TEMP:    r_tc <= i_cfg.data[47:0];
                    REG_PRESS_A: r_pa <= i_cfg.data;
                    REG_PRESS_B: r_pb <= i_cfg.data;
                    REG_P9:      r_p9 <= i_cfg.data[15:0];
                    REG_HUM_A:   r_ha <= i_cfg.data[31:0];
                    REG_HUM_B:   r_hb <= i_cfg.data[31:0];
                    default: ;
                endcase
            end
        end
        r_flag <= n_flag;
        r_raw  <= n_raw;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_rc   <= n_rc;
        r_rs   <= n_rs;
        r_rx   <= n_rx;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_inv  <= n_inv;
        r_oval <= n_oval;
        r_oinv <= n_oinv;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input taken again right after an accept");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt == 5'd31) |=> (r_state == S_PRESS) && (r_step == 4'd9))
        else $error("divide did not return to the pressure sequence");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("output loaded outside the finish state");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oinv |-> (r_oval == '0))
        else $error("invalid result with nonzero value");

endmodule
